// ----- hw/rtl/brf_pkg.sv -----
// Package for the byte ring FIFO: operation kinds, match verdict codes,
// field widths and the stage struct shared by the top level and the match unit.
// No dependencies.
`default_nettype none

package brf_pkg;

   localparam int BYTE_W     = 8;
   localparam int KIND_W     = 3;
   localparam int CODE_W     = 2;
   localparam int REQ_DATA_W = 16;
   localparam int REQ_USER_W = 4;
   localparam int RSP_DATA_W = 24;

   localparam logic [KIND_W-1:0] KIND_ENQ   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_DEQ   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_PEEK  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd3;
   localparam logic [KIND_W-1:0] KIND_MATCH = 3'd4;

   localparam logic [CODE_W-1:0] V_PROGRESS = 2'd0;
   localparam logic [CODE_W-1:0] V_MATCHED  = 2'd1;
   localparam logic [CODE_W-1:0] V_MISMATCH = 2'd2;
   localparam logic [CODE_W-1:0] V_SHORT    = 2'd3;

   // Per-transaction control carried from the accept cycle to the result cycle
   typedef struct packed {
      logic ok;
      logic dout_en;
      logic is_match;
      logic first;
      logic last;
      logic short_run;
   } brf_stage_type;

endpackage

`default_nettype wire

// ----- hw/rtl/brf_ram.sv -----
// Byte store of the ring FIFO: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none

module brf_ram #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [7:0]        wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [7:0]        rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/brf_match.sv -----
// Streamed pattern match unit: keeps match position and verdict, compares one
// pattern byte against the byte read from the store. Depends on brf_pkg.
`default_nettype none

module brf_match
   import brf_pkg::*;
#(
   parameter int PTR_W = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 fire,
   input  wire brf_stage_type        stage,
   input  wire logic [BYTE_W-1:0]    pattern,
   input  wire logic [BYTE_W-1:0]    rd_data,
   output logic      [PTR_W-1:0]     match_pos,
   output logic      [CODE_W-1:0]    match_code
);

   logic [PTR_W-1:0]  pos_ff;
   logic [PTR_W-1:0]  pos_in;
   logic [CODE_W-1:0] verdict_ff;
   logic [CODE_W-1:0] verdict_in;
   logic [PTR_W-1:0]  pos_eff;
   logic [CODE_W-1:0] verdict_eff;

   always_comb begin
      pos_eff     = stage.first ? '0 : pos_ff;
      verdict_eff = stage.first ? V_PROGRESS : verdict_ff;
      pos_in      = pos_eff;
      verdict_in  = verdict_eff;
      if (verdict_eff == V_PROGRESS) begin
         if (stage.short_run) begin
            verdict_in = V_SHORT;
         end else if (rd_data != pattern) begin
            verdict_in = V_MISMATCH;
         end else begin
            // pos_eff < count <= DEPTH-1, so this cannot wrap
            pos_in = pos_eff + 1'b1;
            if (stage.last) begin
               verdict_in = V_MATCHED;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         verdict_ff <= V_PROGRESS;
      end else if (fire) begin
         pos_ff     <= pos_in;
         verdict_ff <= verdict_in;
      end
   end

   assign match_pos  = pos_ff;
   assign match_code = verdict_in;

endmodule

`default_nettype wire

// ----- hw/rtl/byte_ring_fifo_with_peek_and_match_core.sv -----
// Byte ring FIFO with peek and streamed pattern match, top level.
// The request is registered into the stage registers and the byte store read
// register, then moved into the output register once that register is free.
// One item in flight, held in busy until it moves to the output register. A new
// request is taken while the previous result still waits in the output register.
// Reset clears pointers, match state and handshake; the byte store is not cleared.
`default_nettype none

module byte_ring_fifo_with_peek_and_match_core
   import brf_pkg::*;
#(
   parameter int QUEUE_DEPTH = 256
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // data_in[7:0], peek_offset[15:8]
   input  wire logic [REQ_USER_W-1:0] req_tuser,  // kind[2:0], match_first[3]
   input  wire logic                  req_tlast,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [RSP_DATA_W-1:0] rsp_tdata   // ok[0], data_out[8:1],
                                                  // fill_count[16:9], match_code[18:17]
);

   localparam int PTR_W = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW    = ((PTR_W > BYTE_W) ? PTR_W : BYTE_W) + 1;
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0]    DEPTH_CW  = CW'(QUEUE_DEPTH);

   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic             busy_ff, busy_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   brf_stage_type    stage_ff, stage_in;
   logic [BYTE_W-1:0] fill_ff, fill_in;
   logic [BYTE_W-1:0] pattern_ff;

   logic [KIND_W-1:0] kind;
   logic [BYTE_W-1:0] data_in;
   logic [BYTE_W-1:0] peek_offset;
   logic              match_first;
   logic              accept;
   logic              b_done;
   logic [PTR_W:0]    diff;
   logic [PTR_W-1:0]  cnt;
   logic [CW-1:0]     cnt_ext;
   logic [CW-1:0]     fill_calc;
   logic [PTR_W-1:0]  next_head, next_tail;
   logic              empty, full;
   logic [PTR_W-1:0]  match_pos;
   logic [PTR_W-1:0]  pos_eff;
   logic [CW-1:0]     offset_sel;
   logic [CW-1:0]     addr_sum;
   logic [CW-1:0]     addr_wrap;
   logic              wr_en, rd_en;
   logic [BYTE_W-1:0] rd_data;
   logic [CODE_W-1:0] match_code;
   logic [BYTE_W-1:0] dout;

   assign kind        = req_tuser[KIND_W-1:0];
   assign match_first = req_tuser[KIND_W];
   assign data_in     = req_tdata[BYTE_W-1:0];
   assign peek_offset = req_tdata[2*BYTE_W-1:BYTE_W];

   assign req_tready = !busy_ff;
   assign accept     = req_tvalid && !busy_ff;
   assign b_done     = busy_ff && (!rsp_valid_ff || rsp_tready);

   // Occupancy and ring arithmetic
   always_comb begin
      diff = {1'b0, tail_ff} - {1'b0, head_ff};
      if (tail_ff < head_ff) begin
         diff = diff + (PTR_W+1)'(QUEUE_DEPTH);
      end
      cnt       = diff[PTR_W-1:0];
      cnt_ext   = CW'(cnt);
      next_head = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
      next_tail = (tail_ff == LAST_SLOT) ? '0 : tail_ff + 1'b1;
      empty     = (head_ff == tail_ff);
      full      = (next_tail == head_ff);
      pos_eff   = match_first ? '0 : match_pos;
   end

   // Read address: head plus offset, wrapped once
   always_comb begin
      case (kind)
         KIND_PEEK:  offset_sel = CW'(peek_offset);
         KIND_MATCH: offset_sel = CW'(pos_eff);
         default:    offset_sel = '0;
      endcase
      addr_sum  = CW'(head_ff) + offset_sel;
      addr_wrap = (addr_sum >= DEPTH_CW) ? addr_sum - DEPTH_CW : addr_sum;
   end

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      fill_calc = cnt_ext;
      stage_in  = '0;
      case (kind)
         KIND_ENQ: begin
            if (!full) begin
               stage_in.ok = 1'b1;
               wr_en       = accept;
               tail_in     = next_tail;
               fill_calc   = cnt_ext + 1'b1;
            end
         end
         KIND_DEQ: begin
            if (!empty) begin
               stage_in.ok      = 1'b1;
               stage_in.dout_en = 1'b1;
               rd_en            = accept;
               head_in          = next_head;
               fill_calc        = cnt_ext - 1'b1;
            end
         end
         KIND_PEEK: begin
            if (CW'(peek_offset) < cnt_ext) begin
               stage_in.ok      = 1'b1;
               stage_in.dout_en = 1'b1;
               rd_en            = accept;
            end
         end
         KIND_CLEAR: begin
            stage_in.ok = 1'b1;
            head_in     = '0;
            tail_in     = '0;
            fill_calc   = '0;
         end
         KIND_MATCH: begin
            stage_in.ok        = 1'b1;
            stage_in.is_match  = 1'b1;
            stage_in.first     = match_first;
            stage_in.last      = req_tlast;
            stage_in.short_run = (pos_eff >= cnt);
            rd_en              = accept;
         end
         default: begin
         end
      endcase
      fill_in = fill_calc[BYTE_W-1:0];
   end

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (b_done) begin
         busy_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (b_done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      dout        = stage_ff.dout_en ? rd_data : '0;
      rsp_data_in = {(RSP_DATA_W - 1 - 2*BYTE_W - CODE_W)'(0),
                     (stage_ff.is_match ? match_code : V_PROGRESS),
                     fill_ff, dout, stage_ff.ok};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            head_ff <= head_in;
            tail_ff <= tail_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff   <= stage_in;
         fill_ff    <= fill_in;
         pattern_ff <= data_in;
      end
      if (b_done) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   brf_ram #(
      .DEPTH  (QUEUE_DEPTH),
      .ADDR_W (PTR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (data_in),
      .rd_en   (rd_en),
      .rd_addr (addr_wrap[PTR_W-1:0]),
      .rd_data (rd_data)
   );

   brf_match #(
      .PTR_W (PTR_W)
   ) u_match (
      .clock      (clock),
      .reset      (reset),
      .fire       (b_done && stage_ff.is_match),
      .stage      (stage_ff),
      .pattern    (pattern_ff),
      .rd_data    (rd_data),
      .match_pos  (match_pos),
      .match_code (match_code)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, head_ff} < (PTR_W+1)'(QUEUE_DEPTH)) &&
      ({1'b0, tail_ff} < (PTR_W+1)'(QUEUE_DEPTH)))
      else $error("ring pointer out of range");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      b_done |=> rsp_tvalid && !busy_ff)
      else $error("finished transaction did not reach the output register");

   a_full_holds_tail: assert property (@(posedge clock) disable iff (reset)
      (accept && kind == KIND_ENQ && full) |=> $stable(tail_ff))
      else $error("enqueue into a full ring moved the tail");

   a_empty_holds_head: assert property (@(posedge clock) disable iff (reset)
      (accept && kind == KIND_DEQ && empty) |=> $stable(head_ff))
      else $error("dequeue from an empty ring moved the head");

   a_code_needs_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[2*BYTE_W+CODE_W:2*BYTE_W+1] != V_PROGRESS) |-> rsp_tdata[0])
      else $error("match verdict reported on a failed transaction");

endmodule

`default_nettype wire
